@@ sv/sbph_pkg.sv @@
// Package for the spectrum bar / falling peak dot block.
// Constants, payload types, the magnitude threshold table and the column map.
// No dependencies.
package sbph_pkg;

   localparam int COLUMNS     = 128;
   localparam int MAX_ROW     = 63;
   localparam int HEIGHT_CAP  = 63;
   localparam int FALL_TENTHS = 7;

   localparam int COL_W = 7;
   localparam int MAG_W = 24;
   localparam int HGT_W = 6;
   localparam int ROW_W = 6;
   localparam int LVL_W = MAG_W + 1;
   localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int POS_W = $clog2(10 * MAX_ROW + FALL_TENTHS + 1);

   // floor(x / 10) as (x * 6554) >> 16, exact for x below 4096
   localparam int DIV10_MUL   = 6554;
   localparam int DIV10_SHIFT = 16;
   localparam int DIV10_W     = POS_W + 13;

   typedef logic [COL_W-1:0] column_type;
   typedef logic [MAG_W-1:0] magnitude_type;
   typedef logic [HGT_W-1:0] height_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type    old_pos;
      height_type height;
   } dot_in_type;

   typedef struct packed {
      pos_type new_pos;
      logic    dot_valid;
      row_type dot_row;
   } dot_out_type;

   // LEVEL[k-1] = ceil(256 * 10^(k/20)); height >= k when magnitude + 256 reaches it
   localparam logic [LVL_W-1:0] LEVEL [HEIGHT_CAP] = '{
      25'd288, 25'd323, 25'd362, 25'd406, 25'd456, 25'd511, 25'd574, 25'd644,
      25'd722, 25'd810, 25'd909, 25'd1020, 25'd1144, 25'd1284, 25'd1440, 25'd1616,
      25'd1813, 25'd2034, 25'd2282, 25'd2560, 25'd2873, 25'd3223, 25'd3617, 25'd4058,
      25'd4553, 25'd5108, 25'd5732, 25'd6431, 25'd7216, 25'd8096, 25'd9084, 25'd10192,
      25'd11436, 25'd12831, 25'd14396, 25'd16153, 25'd18124, 25'd20335, 25'd22817,
      25'd25600, 25'd28724, 25'd32229, 25'd36161, 25'd40574, 25'd45524, 25'd51079,
      25'd57312, 25'd64305, 25'd72151, 25'd80955, 25'd90833, 25'd101916, 25'd114351,
      25'd128304, 25'd143960, 25'd161526, 25'd181235, 25'd203349, 25'd228161,
      25'd256000, 25'd287237, 25'd322285, 25'd361610
   };

   typedef idx_type idx_map_type [2**COL_W];

   function automatic idx_map_type build_idx_map();
      idx_map_type m;
      for (int i = 0; i < 2**COL_W; i++) begin
         m[i] = IDX_W'(i % COLUMNS);
      end
      return m;
   endfunction

   localparam idx_map_type IDX_MAP = build_idx_map();

   // Thresholds rise monotonically, so the height is the count of levels reached.
   function automatic height_type bar_height_of(magnitude_type mag);
      logic [LVL_W-1:0]      v;
      logic [HEIGHT_CAP-1:0] hit;
      height_type            h;
      v = {1'b0, mag} + LVL_W'(256);
      for (int k = 0; k < HEIGHT_CAP; k++) begin
         hit[k] = (v >= LEVEL[k]);
      end
      h = HGT_W'($countones(hit));
      if (int'(h) > MAX_ROW) begin
         h = HGT_W'(MAX_ROW);
      end
      return h;
   endfunction

endpackage

@@ sv/sbph_if.sv @@
// Request and response channel interfaces: valid/ready handshake plus payload.
// Depends on sbph_pkg.
interface sbph_req_if;
   import sbph_pkg::*;

   logic          valid;
   logic          ready;
   column_type    column;
   magnitude_type magnitude;

   modport source (output valid, output column, output magnitude, input ready);
   modport sink   (input valid, input column, input magnitude, output ready);
endinterface

interface sbph_rsp_if;
   import sbph_pkg::*;

   logic       valid;
   logic       ready;
   column_type column_out;
   height_type bar_height;
   logic       dot_valid;
   row_type    dot_row;

   modport source (output valid, output column_out, output bar_height,
                   output dot_valid, output dot_row, input ready);
   modport sink   (input valid, input column_out, input bar_height,
                   input dot_valid, input dot_row, output ready);
endinterface

@@ sv/sbph_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sbph_dot_update.sv @@
// Falling dot update: snap to the bar top or fall by 7 tenths, clamp, derive row.
// Depends on sbph_pkg.
module sbph_dot_update (
   input  sbph_pkg::dot_in_type  dot_in,
   output sbph_pkg::dot_out_type dot_out
);
   import sbph_pkg::*;

   pos_type              span;
   pos_type              top;
   pos_type              fall;
   pos_type              fall_clamped;
   logic [DIV10_W-1:0]   prod;

   always_comb begin
      span = POS_W'(MAX_ROW) - POS_W'(dot_in.height);
      top  = (span << 3) + (span << 1);
      fall = dot_in.old_pos + POS_W'(FALL_TENTHS);
      fall_clamped = (fall > POS_W'(10 * MAX_ROW)) ? POS_W'(10 * MAX_ROW) : fall;
      prod = DIV10_W'(fall_clamped) * DIV10_W'(DIV10_MUL);

      if (dot_in.old_pos > top) begin
         // dot sits below the bar top: snap up, hide it
         dot_out.new_pos   = top;
         dot_out.dot_valid = 1'b0;
         dot_out.dot_row   = '0;
      end else begin
         dot_out.new_pos   = fall_clamped;
         dot_out.dot_valid = 1'b1;
         dot_out.dot_row   = ROW_W'(prod >> DIV10_SHIFT);
      end
   end

endmodule

@@ sv/spectrum_bar_peak_hold.sv @@
// Spectrum bar with falling peak dot, one per column.
// Pipeline: an accepted request sits in stage 1 while its RAM read is in flight, then
// the dot update result is registered in the response register until it is taken.
// Throughput: one request per cycle unless the response stalls. The per-column dot
// store is one RAM (one read port, one write port), forwarding same-column repeats.
// Reset: synchronous, clears all per-column valid bits at once (no clearing pass).
module spectrum_bar_peak_hold (
   input  logic             clock,
   input  logic             reset,
   sbph_req_if.sink         req_bus,
   sbph_rsp_if.source       rsp_bus
);
   import sbph_pkg::*;

   // stage 1: RAM read in flight
   logic         s1_valid_ff, s1_valid_in;
   column_type   s1_column_ff, s1_column_in;
   idx_type      s1_idx_ff, s1_idx_in;
   height_type   s1_height_ff, s1_height_in;
   logic         s1_known_ff, s1_known_in;
   logic         s1_bypass_ff, s1_bypass_in;
   pos_type      s1_bypass_pos_ff, s1_bypass_pos_in;

   // response register
   logic         out_valid_ff, out_valid_in;
   column_type   out_column_ff, out_column_in;
   height_type   out_height_ff, out_height_in;
   logic         out_dot_valid_ff, out_dot_valid_in;
   row_type      out_row_ff, out_row_in;

   logic [COLUMNS-1:0] row_valid_ff, row_valid_in;

   logic         s1_adv;
   logic         accept;
   logic         wr_en;
   idx_type      req_idx;
   pos_type      ram_rdata;
   dot_in_type   dot_in;
   dot_out_type  dot_out;

   assign s1_adv        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign accept        = req_bus.valid && req_bus.ready;
   assign wr_en         = s1_valid_ff && s1_adv;
   assign req_idx       = IDX_MAP[req_bus.column];

   sbph_ram #(
      .WIDTH (POS_W),
      .DEPTH (COLUMNS)
   ) u_dot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff),
      .wr_data (dot_out.new_pos),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ram_rdata)
   );

   always_comb begin
      dot_in.height  = s1_height_ff;
      if (s1_bypass_ff) begin
         dot_in.old_pos = s1_bypass_pos_ff;
      end else if (s1_known_ff) begin
         dot_in.old_pos = ram_rdata;
      end else begin
         dot_in.old_pos = '0;
      end
   end

   sbph_dot_update u_dot_update (
      .dot_in  (dot_in),
      .dot_out (dot_out)
   );

   always_comb begin
      s1_valid_in      = accept || (s1_valid_ff && !s1_adv);
      s1_column_in     = s1_column_ff;
      s1_idx_in        = s1_idx_ff;
      s1_height_in     = s1_height_ff;
      s1_known_in      = s1_known_ff;
      s1_bypass_in     = s1_bypass_ff;
      s1_bypass_pos_in = s1_bypass_pos_ff;
      if (accept) begin
         s1_column_in     = req_bus.column;
         s1_idx_in        = req_idx;
         s1_height_in     = bar_height_of(req_bus.magnitude);
         s1_known_in      = row_valid_ff[req_idx];
         // forward the entry being written this cycle
         s1_bypass_in     = wr_en && (s1_idx_ff == req_idx);
         s1_bypass_pos_in = dot_out.new_pos;
      end

      out_valid_in     = wr_en || (out_valid_ff && !rsp_bus.ready);
      out_column_in    = out_column_ff;
      out_height_in    = out_height_ff;
      out_dot_valid_in = out_dot_valid_ff;
      out_row_in       = out_row_ff;
      if (wr_en) begin
         out_column_in    = s1_column_ff;
         out_height_in    = s1_height_ff;
         out_dot_valid_in = dot_out.dot_valid;
         out_row_in       = dot_out.dot_row;
      end

      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[s1_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_column_ff     <= s1_column_in;
      s1_idx_ff        <= s1_idx_in;
      s1_height_ff     <= s1_height_in;
      s1_known_ff      <= s1_known_in;
      s1_bypass_ff     <= s1_bypass_in;
      s1_bypass_pos_ff <= s1_bypass_pos_in;
      out_column_ff    <= out_column_in;
      out_height_ff    <= out_height_in;
      out_dot_valid_ff <= out_dot_valid_in;
      out_row_ff       <= out_row_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.column_out = out_column_ff;
   assign rsp_bus.bar_height = out_height_ff;
   assign rsp_bus.dot_valid  = out_dot_valid_ff;
   assign rsp_bus.dot_row    = out_row_ff;

   a_hidden_dot_row_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.dot_valid |-> rsp_bus.dot_row == '0)
      else $error("hidden dot carries a nonzero row");

   a_stored_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> dot_out.new_pos <= POS_W'(10 * MAX_ROW))
      else $error("dot position written beyond the bottom row");

   a_bypass_follows_write: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_bypass_ff && $past(accept) |-> $past(wr_en))
      else $error("forwarded dot position without a preceding write");

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> row_valid_ff == '0)
      else $error("column valid bits not cleared by reset");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for spectrum_bar_peak_hold: directed table, quiet column, random frames.
// Each accepted response is checked against a typed table entry or a bar and dot predictor.
// Depends on sbph_pkg, sbph_if and the spectrum_bar_peak_hold top level.
module tb;
   import sbph_pkg::*;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int DIRECTED_ROWS = 22;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      column_type column_out;
      height_type bar_height;
      logic       dot_valid;
      row_type    dot_row;
   } bar_result_type;

   typedef struct packed {
      column_type     column;
      magnitude_type  magnitude;
      logic           typed;
      bar_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   sbph_req_if req_bus ();
   sbph_rsp_if rsp_bus ();

   spectrum_bar_peak_hold i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   int             dot_tenths [COLUMNS];
   bar_result_type pending_bars [$];
   stim_row_type   directed_rows [DIRECTED_ROWS];
   int             error_count;
   int             requests_sent;
   int             burst_left;
   int             timeout_cycles;
   int             sink_mode = 0;
   int             sink_mode_left = 0;
   int             sink_phase = 0;
   bar_result_type seen_bar;
   bar_result_type oldest_bar;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bar height from the threshold table, then the falling-dot update of one column.
   function automatic bar_result_type predict_bar(column_type col, magnitude_type mag);
      logic [LVL_W-1:0] level_in;
      int               height;
      int               top_tenths;
      int               tenths;
      int               slot;
      bar_result_type   r;
      level_in = {1'b0, mag} + LVL_W'(256);
      height = 0;
      for (int k = 0; k < HEIGHT_CAP; k++) begin
         if (level_in >= LEVEL[k]) begin
            height = k + 1;
         end
      end
      if (height > MAX_ROW) begin
         height = MAX_ROW;
      end
      top_tenths = 10 * (MAX_ROW - height);
      slot = int'(col) % COLUMNS;
      tenths = dot_tenths[slot];
      r.column_out = col;
      r.bar_height = height_type'(height);
      r.dot_valid = 1'b0;
      r.dot_row = '0;
      if (tenths > top_tenths) begin
         // dot sits below the bar top: snap up, hide it
         tenths = top_tenths;
      end else begin
         tenths = tenths + FALL_TENTHS;
         if (tenths > 10 * MAX_ROW) begin
            tenths = 10 * MAX_ROW;
         end
         r.dot_valid = 1'b1;
         r.dot_row = row_type'(tenths / 10);
      end
      dot_tenths[slot] = tenths;
      return r;
   endfunction

   function automatic magnitude_type random_magnitude();
      int k;
      case ($urandom_range(0, 3))
         0: return magnitude_type'($urandom());
         1: return magnitude_type'($urandom()) >> $urandom_range(0, MAG_W - 1);
         2: begin
            // land on, just under or just over a height threshold
            k = $urandom_range(0, HEIGHT_CAP - 1);
            return magnitude_type'(int'(LEVEL[k]) - 256 + int'($urandom_range(0, 2)) - 1);
         end
         default: return magnitude_type'($urandom_range(0, 600));
      endcase
   endfunction

   // Drive one request, hold it until accepted, then record the expected response.
   task automatic push_request(input column_type col, input magnitude_type mag,
                               input logic typed, input bar_result_type want);
      bar_result_type predicted;
      int             gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 40);
      end
      req_bus.valid     <= 1'b1;
      req_bus.column    <= col;
      req_bus.magnitude <= mag;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      burst_left--;
      requests_sent++;
      predicted = predict_bar(col, mag);
      pending_bars.push_back(typed ? want : predicted);
   endtask

   // Receiver: ready follows a mode, drawn at random and redrawn when its countdown runs out.
   always @(posedge clock) begin
      if (sink_mode_left == 0) begin
         sink_mode = $urandom_range(0, 3);
         sink_mode_left = $urandom_range(20, 200);
      end
      sink_mode_left--;
      sink_phase++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         case (sink_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= (sink_phase % 3) != 0;
            default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen_bar.column_out = rsp_bus.column_out;
         seen_bar.bar_height = rsp_bus.bar_height;
         seen_bar.dot_valid  = rsp_bus.dot_valid;
         seen_bar.dot_row    = rsp_bus.dot_row;
         if (pending_bars.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected response: col=%0d height=%0d dot=%0b row=%0d",
                        seen_bar.column_out, seen_bar.bar_height,
                        seen_bar.dot_valid, seen_bar.dot_row);
            end
         end else begin
            oldest_bar = pending_bars.pop_front();
            if (seen_bar.column_out !== oldest_bar.column_out ||
                seen_bar.bar_height !== oldest_bar.bar_height ||
                seen_bar.dot_valid  !== oldest_bar.dot_valid  ||
                seen_bar.dot_row    !== oldest_bar.dot_row) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display({"mismatch: expected col=%0d height=%0d dot=%0b row=%0d, ",
                            "got col=%0d height=%0d dot=%0b row=%0d"},
                           oldest_bar.column_out, oldest_bar.bar_height,
                           oldest_bar.dot_valid, oldest_bar.dot_row,
                           seen_bar.column_out, seen_bar.bar_height,
                           seen_bar.dot_valid, seen_bar.dot_row);
               end
            end
         end
      end
   end

   initial begin
      for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++) begin
         @(posedge clock);
      end
      $display("FAIL spectrum_bar_peak_hold");
      $finish;
   end

   initial begin
      int          mode;
      int          start_col;
      int          run_len;
      int          rounds;
      int          width;
      column_type  col;
      logic        paused;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.column    = '0;
      req_bus.magnitude = '0;
      error_count       = 0;
      requests_sent     = 0;
      burst_left        = 0;
      paused            = 1'b0;
      for (int i = 0; i < COLUMNS; i++) begin
         dot_tenths[i] = 0;
      end

      directed_rows = '{
         // fresh column: dot starts at the top row and falls
         '{7'd0,   24'd0,        1'b1, '{7'd0,   6'd0,  1'b1, 6'd0}},
         '{7'd0,   24'd0,        1'b1, '{7'd0,   6'd0,  1'b1, 6'd1}},
         // full scale saturates the bar; second hit hides the dot
         '{7'd127, 24'hFFFFFF,   1'b1, '{7'd127, 6'd63, 1'b1, 6'd0}},
         '{7'd127, 24'hFFFFFF,   1'b1, '{7'd127, 6'd63, 1'b0, 6'd0}},
         '{7'd127, 24'd0,        1'b1, '{7'd127, 6'd0,  1'b1, 6'd0}},
         // first threshold: just under, exactly on
         '{7'd1,   24'd31,       1'b1, '{7'd1,   6'd0,  1'b1, 6'd0}},
         '{7'd2,   24'd32,       1'b1, '{7'd2,   6'd1,  1'b1, 6'd0}},
         // last threshold: on, and one below
         '{7'd3,   24'd361354,   1'b1, '{7'd3,   6'd63, 1'b1, 6'd0}},
         '{7'd4,   24'd361353,   1'b1, '{7'd4,   6'd62, 1'b1, 6'd0}},
         '{7'd4,   24'd361353,   1'b1, '{7'd4,   6'd62, 1'b1, 6'd1}},
         '{7'd4,   24'd0,        1'b1, '{7'd4,   6'd0,  1'b1, 6'd2}},
         '{7'd5,   24'd2304,     1'b1, '{7'd5,   6'd20, 1'b1, 6'd0}},
         '{7'd5,   24'd2303,     1'b0, '0},
         '{7'd64,  24'hAAAAAA,   1'b0, '0},
         '{7'd63,  24'h555555,   1'b0, '0},
         '{7'd0,   24'd0,        1'b0, '0},
         '{7'd0,   24'h800000,   1'b0, '0},
         '{7'd0,   24'h0000FF,   1'b0, '0},
         '{7'd100, 24'h00FFFF,   1'b0, '0},
         '{7'd101, 24'hFF0000,   1'b0, '0},
         '{7'd127, 24'd1000,     1'b0, '0},
         '{7'd127, 24'd1000,     1'b0, '0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         push_request(directed_rows[i].column, directed_rows[i].magnitude,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      // one quiet column long enough for the dot to reach the bottom and clamp
      col = column_type'($urandom_range(0, 127));
      for (int i = 0; i < 100; i++) begin
         push_request(col, magnitude_type'($urandom_range(0, 31)), 1'b0, '0);
      end

      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (!paused && requests_sent >= DIRECTED_ROWS + RANDOM_ITEMS / 2) begin
            // hold off until every response is back
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            while (pending_bars.size() != 0) @(posedge clock);
            burst_left = 0;
         end
         mode = $urandom_range(0, 19);
         if (mode < 10) begin
            // partial frame sweep in column order
            start_col = $urandom_range(0, 127);
            run_len = $urandom_range(4, 48);
            for (int i = 0; i < run_len; i++) begin
               push_request(column_type'(start_col + i), random_magnitude(), 1'b0, '0);
            end
         end else if (mode < 15) begin
            // narrow band over several frames: rare peaks, mostly decay
            start_col = $urandom_range(0, 127);
            width = $urandom_range(1, 8);
            rounds = $urandom_range(3, 12);
            for (int r = 0; r < rounds; r++) begin
               for (int i = 0; i < width; i++) begin
                  push_request(column_type'(start_col + i),
                               ($urandom_range(0, 3) == 0) ? random_magnitude()
                                  : magnitude_type'($urandom_range(0, 400)),
                               1'b0, '0);
               end
            end
         end else if (mode < 18) begin
            // same column back to back
            col = column_type'($urandom_range(0, 127));
            run_len = $urandom_range(2, 8);
            for (int i = 0; i < run_len; i++) begin
               push_request(col, random_magnitude(), 1'b0, '0);
            end
         end else if (mode == 18) begin
            col = column_type'($urandom_range(0, 127));
            run_len = $urandom_range(60, 100);
            for (int i = 0; i < run_len; i++) begin
               push_request(col, magnitude_type'($urandom_range(0, 31)), 1'b0, '0);
            end
         end else begin
            push_request(column_type'($urandom()), magnitude_type'($urandom()), 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_bars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_bars.size() == 0) begin
         $display("PASS spectrum_bar_peak_hold");
      end else begin
         $display("FAIL spectrum_bar_peak_hold");
      end
      $finish;
   end

endmodule
